/* src/bhpq_pkg.sv */
package bhpq_pkg;

    // queue geometry
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEVELS   = $clog2(CAPACITY + 1);
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ROW_W    = (LEVELS > 2) ? LEVELS - 2 : 1;
    localparam int IDX_W    = ROW_W + 1;
    localparam int ROW_DW   = 2 * KEY_W;
    localparam int EXT_W    = LEVELS + 1;

    // operation codes
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // token that walks along the row of level cells
    typedef struct packed {
        logic             vld;
        logic             up;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } rdreq_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [ROW_DW-1:0] data;
    } wrreq_t;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [IDX_W-1:0] idx;
    } loc_t;

    // sibling-pair rows held by one level
    function automatic int level_rows(input int lvl);
        int first;
        int n;
        begin
            first = (1 << lvl) - 1;
            n = CAPACITY - first;
            if (n > (1 << lvl))
                n = 1 << lvl;
            return (n + 1) >> 1;
        end
    endfunction

    // true when key a belongs above key b
    function automatic logic above(input logic mode, input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b);
        begin
            return mode ? (a > b) : (a < b);
        end
    endfunction

    // heap position to level and index within the level
    function automatic loc_t pos_split(input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] q;
        int             lvl;
        loc_t           r;
        begin
            q = {1'b0, pos} + 1'b1;
            lvl = 0;
            for (int i = 0; i <= CNT_W; i++)
            begin
                if (q[i])
                    lvl = i;
            end
            r.lvl = LVL_W'(lvl);
            r.idx = IDX_W'(q - ((CNT_W + 1)'(1) << lvl));
            return r;
        end
    endfunction

endpackage

/* src/bhpq_in_if.sv */
interface bhpq_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [bhpq_pkg::KEY_W-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink (input valid, input func, input key, output ready);
endinterface

/* src/bhpq_out_if.sv */
interface bhpq_out_if;
    logic                       valid;
    logic                       ready;
    logic [bhpq_pkg::KEY_W-1:0] value;
    logic                       ok;
    logic [bhpq_pkg::CNT_W-1:0] count;
    logic                       is_empty;

    modport source (output valid, output value, output ok, output count, output is_empty,
                    input ready);
    modport sink (input valid, input value, input ok, input count, input is_empty,
                  output ready);
endinterface

/* src/bhpq_cfg_if.sv */
interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/bhpq_ram.sv */
module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* src/bhpq_cell.sv */
module bhpq_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bhpq_pkg::LVL_W-1:0]    level_id,
    input  logic                          order_mode,
    input  logic [bhpq_pkg::CNT_W-1:0]    count,
    input  bhpq_pkg::tok_t                launch_tok,
    input  bhpq_pkg::tok_t                from_up,
    input  bhpq_pkg::tok_t                from_down,
    output bhpq_pkg::tok_t                to_up,
    output bhpq_pkg::tok_t                to_down,
    input  bhpq_pkg::rdreq_t              ext_rd,
    input  bhpq_pkg::rdreq_t              nbr_up_rd,
    input  bhpq_pkg::rdreq_t              nbr_down_rd,
    output bhpq_pkg::rdreq_t              up_rd,
    output bhpq_pkg::rdreq_t              down_rd,
    output bhpq_pkg::rdreq_t              ram_rd,
    output bhpq_pkg::wrreq_t              ram_wr,
    input  logic [bhpq_pkg::ROW_DW-1:0]   own_q,
    input  logic [bhpq_pkg::ROW_DW-1:0]   up_q,
    input  logic [bhpq_pkg::ROW_DW-1:0]   down_q,
    output logic                          busy,
    output logic                          done
);

    localparam int K = bhpq_pkg::KEY_W;

    bhpq_pkg::tok_t tok_reg, tok_next;
    logic           cmp_reg, cmp_next;
    bhpq_pkg::tok_t incoming;

    logic                         is_root;
    logic                         is_last;
    logic                         req_phase;
    logic                         cmp_phase;
    logic [bhpq_pkg::ROW_W-1:0]   own_row;
    logic [bhpq_pkg::ROW_W-1:0]   par_row;
    logic [bhpq_pkg::ROW_W-1:0]   kid_row;
    logic [K-1:0]                 par_key;
    logic [K-1:0]                 lkey;
    logic [K-1:0]                 rkey;
    logic [K-1:0]                 best_key;
    logic [K-1:0]                 move_key;
    logic [K-1:0]                 put_key;
    logic [bhpq_pkg::EXT_W-1:0]   base_next;
    logic [bhpq_pkg::EXT_W-1:0]   kid_pos;
    logic [bhpq_pkg::EXT_W-1:0]   cnt_ext;
    logic                         l_ok;
    logic                         r_ok;
    logic                         pick_r;
    logic                         climb;
    logic                         sink;
    logic                         move;

    assign is_root   = (level_id == '0);
    assign is_last   = (level_id == bhpq_pkg::LVL_W'(bhpq_pkg::LEVELS - 1));
    assign req_phase = tok_reg.vld && !cmp_reg;
    assign cmp_phase = tok_reg.vld && cmp_reg;
    assign busy      = tok_reg.vld;

    assign own_row = bhpq_pkg::ROW_W'(tok_reg.idx >> 1);
    assign par_row = bhpq_pkg::ROW_W'(tok_reg.idx >> 2);
    assign kid_row = tok_reg.idx[bhpq_pkg::ROW_W-1:0];

    // token arrives from the launcher or from a neighbor
    always_comb
    begin
        if (launch_tok.vld)
            incoming = launch_tok;
        else if (from_up.vld)
            incoming = from_up;
        else
            incoming = from_down;
    end

    // read requests: own row and the neighbor row in the direction of travel
    always_comb
    begin
        up_rd.en    = req_phase && tok_reg.up && !is_root;
        up_rd.row   = par_row;
        down_rd.en  = req_phase && !tok_reg.up && !is_last;
        down_rd.row = kid_row;
        if (req_phase)
        begin
            ram_rd.en  = 1'b1;
            ram_rd.row = own_row;
        end
        else if (nbr_up_rd.en)
            ram_rd = nbr_up_rd;
        else if (nbr_down_rd.en)
            ram_rd = nbr_down_rd;
        else
            ram_rd = ext_rd;
    end

    // compare toward the parent on the way up
    assign par_key = tok_reg.idx[1] ? up_q[2*K-1:K] : up_q[K-1:0];
    assign climb   = !is_root && bhpq_pkg::above(order_mode, tok_reg.key, par_key);

    // compare against the children on the way down
    assign base_next = (bhpq_pkg::EXT_W'(1) << ((bhpq_pkg::LVL_W + 1)'(level_id) + 1'b1))
                       - 1'b1;
    assign kid_pos  = base_next + (bhpq_pkg::EXT_W'(tok_reg.idx) << 1);
    assign cnt_ext  = bhpq_pkg::EXT_W'(count);
    assign l_ok     = !is_last && (kid_pos < cnt_ext);
    assign r_ok     = !is_last && ((kid_pos + 1'b1) < cnt_ext);
    assign lkey     = down_q[K-1:0];
    assign rkey     = down_q[2*K-1:K];
    assign pick_r   = r_ok && bhpq_pkg::above(order_mode, rkey, lkey);
    assign best_key = pick_r ? rkey : lkey;
    assign sink     = l_ok && bhpq_pkg::above(order_mode, best_key, tok_reg.key);

    assign move     = tok_reg.up ? climb : sink;
    assign move_key = tok_reg.up ? par_key : best_key;
    assign put_key  = move ? move_key : tok_reg.key;

    // write back own row with one half replaced
    always_comb
    begin
        ram_wr.en   = cmp_phase;
        ram_wr.row  = own_row;
        ram_wr.data = own_q;
        if (tok_reg.idx[0])
            ram_wr.data[2*K-1:K] = put_key;
        else
            ram_wr.data[K-1:0] = put_key;
    end

    // hand the token to a neighbor or finish
    always_comb
    begin
        to_up.vld   = cmp_phase && tok_reg.up && climb;
        to_up.up    = 1'b1;
        to_up.key   = tok_reg.key;
        to_up.idx   = tok_reg.idx >> 1;
        to_down.vld = cmp_phase && !tok_reg.up && sink;
        to_down.up  = 1'b0;
        to_down.key = tok_reg.key;
        to_down.idx = {tok_reg.idx[bhpq_pkg::ROW_W-1:0], pick_r};
        done        = cmp_phase && !move;
    end

    // token phase sequencing
    always_comb
    begin
        tok_next = tok_reg;
        cmp_next = cmp_reg;
        if (incoming.vld)
        begin
            tok_next = incoming;
            cmp_next = 1'b0;
        end
        else if (req_phase)
            cmp_next = 1'b1;
        else if (cmp_phase)
            tok_next.vld = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            cmp_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            cmp_reg <= cmp_next;
        end
    end

endmodule

/* src/binary_heap_priority_queue.sv */
// Binary-heap priority queue, 64 entries of 32-bit unsigned keys.
// req channel: func (push, pop, peek) and key; one rsp item per req item
// carrying value, ok, count and is_empty. cfg channel writes order_mode
// (0 smallest first, 1 largest first); write it only while the queue is idle.
// The heap is stored level by level, one cell per level holding sibling-pair
// rows in a small RAM; a sift token walks the row of cells, and at each level
// it reads the rows, then compares and writes back.
// The response is registered and shows in the cycle after acceptance.
// Peek, failed ops and a pop of the last entry leave the block idle; any other
// push or pop keeps it busy until its sift token finishes (up to 7 levels).
// A new item is taken only while no sift runs and the response register is
// empty or being drained; a stalled rsp holds its item and blocks req.
// Reset empties the queue and selects smallest first; stored keys are not
// cleared and there is no clearing pass.
module binary_heap_priority_queue (
    input  logic             clk,
    input  logic             rst_n,
    bhpq_in_if.sink          req,
    bhpq_out_if.source       rsp,
    bhpq_cfg_if.sink         cfg
);

    localparam int K = bhpq_pkg::KEY_W;
    localparam int L = bhpq_pkg::LEVELS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_SIFT  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [bhpq_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          mode_reg;
    logic [K-1:0]                  root_reg;
    bhpq_pkg::tok_t                launch_reg, launch_next;
    logic [bhpq_pkg::LVL_W-1:0]    launch_lvl_reg, launch_lvl_next;
    logic [bhpq_pkg::LVL_W-1:0]    fetch_lvl_reg, fetch_lvl_next;
    logic [bhpq_pkg::IDX_W-1:0]    fetch_idx_reg, fetch_idx_next;
    logic                          out_vld_reg, out_vld_next;
    logic [K-1:0]                  value_reg, value_next;
    logic                          ok_reg, ok_next;
    logic [bhpq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          empty_reg, empty_next;

    logic                          accept;
    bhpq_pkg::loc_t                loc_push;
    bhpq_pkg::loc_t                loc_last;
    logic [K-1:0]                  last_key;

    bhpq_pkg::tok_t                launch_c [L];
    bhpq_pkg::tok_t                to_up    [L];
    bhpq_pkg::tok_t                to_down  [L];
    bhpq_pkg::tok_t                from_up  [L];
    bhpq_pkg::tok_t                from_dn  [L];
    bhpq_pkg::rdreq_t              ext_rd   [L];
    bhpq_pkg::rdreq_t              up_rd    [L];
    bhpq_pkg::rdreq_t              down_rd  [L];
    bhpq_pkg::rdreq_t              nbr_up   [L];
    bhpq_pkg::rdreq_t              nbr_dn   [L];
    bhpq_pkg::rdreq_t              ram_rd   [L];
    bhpq_pkg::wrreq_t              ram_wr   [L];
    logic [bhpq_pkg::ROW_DW-1:0]   ram_q    [L];
    logic [bhpq_pkg::ROW_DW-1:0]   up_q     [L];
    logic [bhpq_pkg::ROW_DW-1:0]   down_q   [L];
    logic [L-1:0]                  busy_vec;
    logic [L-1:0]                  done_vec;

    // row of level cells, each with its own pair-row RAM
    for (genvar g = 0; g < L; g++)
    begin : g_lvl
        localparam int ROWS = bhpq_pkg::level_rows(g);
        localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

        assign launch_c[g]   = launch_reg.vld && (launch_lvl_reg == bhpq_pkg::LVL_W'(g))
                               ? launch_reg : '0;
        assign ext_rd[g].en  = (state_reg == ST_FETCH) && (fetch_lvl_reg == bhpq_pkg::LVL_W'(g));
        assign ext_rd[g].row = bhpq_pkg::ROW_W'(fetch_idx_reg >> 1);

        if (g > 0)
        begin : g_up
            assign from_up[g] = to_down[g-1];
            assign nbr_up[g]  = down_rd[g-1];
            assign up_q[g]    = ram_q[g-1];
        end
        else
        begin : g_top
            assign from_up[g] = '0;
            assign nbr_up[g]  = '0;
            assign up_q[g]    = '0;
        end

        if (g < L - 1)
        begin : g_dn
            assign from_dn[g] = to_up[g+1];
            assign nbr_dn[g]  = up_rd[g+1];
            assign down_q[g]  = ram_q[g+1];
        end
        else
        begin : g_bot
            assign from_dn[g] = '0;
            assign nbr_dn[g]  = '0;
            assign down_q[g]  = '0;
        end

        bhpq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .level_id    (bhpq_pkg::LVL_W'(g)),
            .order_mode  (mode_reg),
            .count       (cnt_reg),
            .launch_tok  (launch_c[g]),
            .from_up     (from_up[g]),
            .from_down   (from_dn[g]),
            .to_up       (to_up[g]),
            .to_down     (to_down[g]),
            .ext_rd      (ext_rd[g]),
            .nbr_up_rd   (nbr_up[g]),
            .nbr_down_rd (nbr_dn[g]),
            .up_rd       (up_rd[g]),
            .down_rd     (down_rd[g]),
            .ram_rd      (ram_rd[g]),
            .ram_wr      (ram_wr[g]),
            .own_q       (ram_q[g]),
            .up_q        (up_q[g]),
            .down_q      (down_q[g]),
            .busy        (busy_vec[g]),
            .done        (done_vec[g])
        );

        bhpq_ram #(
            .WIDTH (bhpq_pkg::ROW_DW),
            .DEPTH (ROWS)
        ) u_ram (
            .clk     (clk),
            .rd_en   (ram_rd[g].en),
            .rd_addr (ram_rd[g].row[AW-1:0]),
            .rd_data (ram_q[g]),
            .wr_en   (ram_wr[g].en),
            .wr_addr (ram_wr[g].row[AW-1:0]),
            .wr_data (ram_wr[g].data)
        );
    end

    // handshakes
    assign req.ready = (state_reg == ST_IDLE) && (!out_vld_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid    = out_vld_reg;
    assign rsp.value    = value_reg;
    assign rsp.ok       = ok_reg;
    assign rsp.count    = count_reg;
    assign rsp.is_empty = empty_reg;

    // slot of the next push and of the last entry
    assign loc_push = bhpq_pkg::pos_split(cnt_reg);
    assign loc_last = bhpq_pkg::pos_split(cnt_reg - 1'b1);
    assign last_key = fetch_idx_reg[0] ? ram_q[fetch_lvl_reg][2*K-1:K]
                                       : ram_q[fetch_lvl_reg][K-1:0];

    // operation sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        launch_next     = '0;
        launch_lvl_next = launch_lvl_reg;
        fetch_lvl_next  = fetch_lvl_reg;
        fetch_idx_next  = fetch_idx_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        value_next      = value_reg;
        ok_next         = ok_reg;
        count_next      = count_reg;
        empty_next      = empty_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_vld_next = 1'b1;
                    value_next   = '0;
                    ok_next      = 1'b0;
                    case (req.func)
                        bhpq_pkg::FUNC_PUSH:
                        begin
                            if (cnt_reg < bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
                            begin
                                ok_next         = 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                                launch_next.vld = 1'b1;
                                launch_next.up  = 1'b1;
                                launch_next.key = req.key;
                                launch_next.idx = loc_push.idx;
                                launch_lvl_next = loc_push.lvl;
                                state_next      = ST_SIFT;
                            end
                        end
                        bhpq_pkg::FUNC_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ok_next    = 1'b1;
                                value_next = root_reg;
                                cnt_next   = cnt_reg - 1'b1;
                                if (cnt_reg != bhpq_pkg::CNT_W'(1))
                                begin
                                    fetch_lvl_next = loc_last.lvl;
                                    fetch_idx_next = loc_last.idx;
                                    state_next     = ST_FETCH;
                                end
                            end
                        end
                        bhpq_pkg::FUNC_PEEK:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ok_next    = 1'b1;
                                value_next = root_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    count_next = cnt_next;
                    empty_next = (cnt_next == '0);
                end
            end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                launch_next.vld = 1'b1;
                launch_next.up  = 1'b0;
                launch_next.key = last_key;
                launch_next.idx = '0;
                launch_lvl_next = '0;
                state_next      = ST_SIFT;
            end
            ST_SIFT:
            begin
                if (|done_vec)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            mode_reg    <= 1'b0;
            launch_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            launch_reg  <= launch_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid && cfg.ready)
                mode_reg <= cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        launch_lvl_reg <= launch_lvl_next;
        fetch_lvl_reg  <= fetch_lvl_next;
        fetch_idx_reg  <= fetch_idx_next;
        value_reg      <= value_next;
        ok_reg         <= ok_next;
        count_reg      <= count_next;
        empty_reg      <= empty_next;
        if (ram_wr[0].en)
            root_reg <= ram_wr[0].data[K-1:0];
    end

    // at most one sift token in the row of cells
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_vec) <= 1)
        else $error("more than one cell holds a sift token");

    // idle means no token in flight and nothing about to launch
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (busy_vec == '0) && !launch_reg.vld)
        else $error("sift activity while idle");

    // a sift can only finish while the sequencer waits for it
    a_done_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
        (|done_vec) |-> (state_reg == ST_SIFT))
        else $error("sift finished outside of sift state");

    // entry count stays within capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // an accepted item always loads the response register
    a_rsp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_vld_reg && (empty_reg == (count_reg == '0)))
        else $error("response not loaded after transfer");

endmodule
